// ===== rtl/olirs_pkg.sv =====
// Shared types and sizing for the ordered record list.
// No dependencies; imported by the list core and its port checker.
package olirs_pkg;

  localparam int CAPACITY = 64;                      // records held at most
  localparam int ADDR_W   = $clog2(CAPACITY);        // record memory address
  localparam int CNT_W    = $clog2(CAPACITY + 1);    // fill count, 0..CAPACITY
  localparam int POS_W    = 6;                       // request position field
  localparam int IDX_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int BYTE_W   = 8;
  localparam int REC_W    = 2 * BYTE_W;              // {initial, age}

  typedef enum logic [2:0] {
    OP_APPEND   = 3'd0,
    OP_GET      = 3'd1,
    OP_SET      = 3'd2,
    OP_INSERT   = 3'd3,
    OP_REMOVE   = 3'd4,
    OP_FIND_AGE = 3'd5,
    OP_FIND_INI = 3'd6,
    OP_CLEAR    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

// ===== rtl/ordered_list_insert_remove_search.sv =====
// Ordered record list core: request sequencer around one record memory.
// Depends on olirs_pkg (sizing, request and status codes).
//
// Holds up to CAPACITY (64) records of {age, name initial} at indices
// 0..count-1. Each request transaction on the slave side (op code in tuser,
// position/age/initial in tdata) yields exactly one result transaction on
// the master side (status in tuser; index, record and count in tdata).
// The block works on one request at a time: s_axis_tready is high only
// while the sequencer is idle. How long a request takes from acceptance to result is set by
// the record memory, which moves at most one record per cycle:
//   append, set, clear, and any rejected request: answered from the check
//   get: reads the addressed record
//   insert at position p: shifts entries from the end down to p, then writes p
//   remove at position p: reads p, then shifts the entries above p down
//   find: compares entries in order from index 0 (stops at the first match)
// so the worst case is a remove at the front of a full list. A finished
// result sits in the output register; the next request is taken
// meanwhile, and its result waits only if the previous one has not been
// taken yet.
// Errors: position at or past the end gives status 1 (insert is only
// allowed at an existing position, checked before fullness); append or
// insert on a full list gives status 2; a find miss gives status 3. Failed
// requests leave the list unchanged and report index and record as zero.
// The record memory has no reset: only entries below the count are used.
module ordered_list_insert_remove_search
  import olirs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [5:0] position, [13:6] age,
                                      // [21:14] name_initial, [23:22] zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [5:0] result_index, [13:6] out_age,
                                      // [21:14] out_initial,
                                      // [28:22] entry_count, [31:29] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,      // check request, launch the walk if one is needed
    S_READ,      // memory read of the addressed record in flight
    S_CAPTURE,   // addressed record available in rd_data
    S_INS,       // shift entries up, from the end down to the position
    S_INS_PUT,   // drop the new record into the opened slot
    S_REM,       // shift entries down, from position+1 to the end
    S_FIND,      // compare entries in order, one per cycle
    S_RESULT     // hand the result to the output register
  } state_t;

  state_t            state;
  op_t               op;
  logic [IDX_W-1:0]  pos;
  logic [REC_W-1:0]  rec;          // {initial, age} of the request
  logic [CNT_W-1:0]  count;

  // walk control: j is the read index, pend marks a read whose data
  // lands in rd_data this cycle (write-back or compare at pend_idx)
  logic [IDX_W-1:0]  j;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;
  logic              scan_end;

  status_t           res_status;
  logic [IDX_W-1:0]  res_index;
  logic [REC_W-1:0]  res_rec;

  logic [POS_W-1:0]  out_index;
  logic [BYTE_W-1:0] out_age;
  logic [BYTE_W-1:0] out_initial;
  logic [6:0]        out_count;
  status_t           out_status;

  // record memory, one write and one registered read per cycle
  logic [REC_W-1:0]  mem [CAPACITY];
  logic [REC_W-1:0]  rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [REC_W-1:0]  mem_wdata;

  logic [IDX_W-1:0]  count_x;
  logic              pos_bad;
  logic              full;
  logic              hit;
  logic              s_accept;

  assign s_axis_tready = (state == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign count_x = IDX_W'(count);
  assign pos_bad = (pos >= count_x);
  assign full    = (count == CNT_W'(CAPACITY));
  assign hit     = (op == OP_FIND_AGE) ? (rd_data[BYTE_W-1:0] == rec[BYTE_W-1:0])
                                       : (rd_data[REC_W-1:BYTE_W] == rec[REC_W-1:BYTE_W]);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos[ADDR_W-1:0];
    mem_wdata = rec;
    case (state)
      S_EXEC: begin
        if (op == OP_APPEND && !full) begin
          mem_we    = 1'b1;
          mem_waddr = count[ADDR_W-1:0];
        end else if (op == OP_SET && !pos_bad) begin
          mem_we    = 1'b1;
        end
      end
      S_INS, S_REM: begin
        mem_we    = pend;
        mem_waddr = pend_idx[ADDR_W-1:0];
        mem_wdata = rd_data;
      end
      S_INS_PUT: begin
        mem_we    = 1'b1;
      end
      default: begin
        mem_we    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[j[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      pend          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // S_RESULT owns the valid flag while it loads a new result
      if (m_axis_tvalid && m_axis_tready && state != S_RESULT) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_accept) begin
            op    <= op_t'(s_axis_tuser);
            pos   <= IDX_W'(s_axis_tdata[5:0]);
            rec   <= {s_axis_tdata[21:14], s_axis_tdata[13:6]};
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          res_rec  <= '0;
          pend     <= 1'b0;
          scan_end <= 1'b0;
          case (op)
            OP_APPEND: begin
              state <= S_RESULT;
              if (full) begin
                res_status <= ST_FULL;
                res_index  <= '0;
              end else begin
                res_status <= ST_OK;
                res_index  <= count_x;
                count      <= count + 1'b1;
              end
            end
            OP_GET, OP_REMOVE: begin
              if (pos_bad) begin
                res_status <= ST_BAD_POS;
                res_index  <= '0;
                state      <= S_RESULT;
              end else begin
                res_status <= ST_OK;
                res_index  <= pos;
                j          <= pos;
                state      <= S_READ;
              end
            end
            OP_SET: begin
              state <= S_RESULT;
              if (pos_bad) begin
                res_status <= ST_BAD_POS;
                res_index  <= '0;
              end else begin
                res_status <= ST_OK;
                res_index  <= pos;
              end
            end
            OP_INSERT: begin
              if (pos_bad) begin
                res_status <= ST_BAD_POS;
                res_index  <= '0;
                state      <= S_RESULT;
              end else if (full) begin
                res_status <= ST_FULL;
                res_index  <= '0;
                state      <= S_RESULT;
              end else begin
                res_status <= ST_OK;
                res_index  <= pos;
                j          <= count_x - 1'b1;
                state      <= S_INS;
              end
            end
            OP_FIND_AGE, OP_FIND_INI: begin
              res_status <= ST_NOT_FOUND;
              res_index  <= '0;
              j          <= '0;
              state      <= S_FIND;
            end
            OP_CLEAR: begin
              res_status <= ST_OK;
              res_index  <= '0;
              count      <= '0;
              state      <= S_RESULT;
            end
            default: begin
              res_status <= ST_OK;
              res_index  <= '0;
              state      <= S_RESULT;
            end
          endcase
        end

        S_READ: begin
          state <= S_CAPTURE;
        end

        S_CAPTURE: begin
          res_rec <= rd_data;
          if (op == OP_REMOVE) begin
            j     <= pos + 1'b1;
            state <= S_REM;
          end else begin
            state <= S_RESULT;
          end
        end

        // entry j is read while entry j+2 receives the data read last cycle
        S_INS: begin
          if (!scan_end) begin
            pend     <= 1'b1;
            pend_idx <= j + 1'b1;
            if (j == pos) begin
              scan_end <= 1'b1;
            end else begin
              j <= j - 1'b1;
            end
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_INS_PUT;
            end
          end
        end

        S_INS_PUT: begin
          count <= count + 1'b1;
          state <= S_RESULT;
        end

        S_REM: begin
          if (j < count_x) begin
            pend     <= 1'b1;
            pend_idx <= j - 1'b1;
            j        <= j + 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              count <= count - 1'b1;
              state <= S_RESULT;
            end
          end
        end

        // compare of entry pend_idx overlaps the read of entry j
        S_FIND: begin
          if (pend && hit) begin
            res_status <= ST_OK;
            res_index  <= pend_idx;
            pend       <= 1'b0;
            state      <= S_RESULT;
          end else if (j < count_x) begin
            pend     <= 1'b1;
            pend_idx <= j;
            j        <= j + 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= S_RESULT;
          end
        end

        S_RESULT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_status    <= res_status;
            out_index     <= POS_W'(res_index);
            out_age       <= res_rec[BYTE_W-1:0];
            out_initial   <= res_rec[REC_W-1:BYTE_W];
            out_count     <= 7'(count);
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {3'b000, out_count, out_initial, out_age, out_index};
  assign m_axis_tuser = out_status;

endmodule

// ===== rtl/olirs_checker.sv =====
// Port-level checks for the ordered record list, bound to the top level.
// Depends on olirs_pkg and ordered_list_insert_remove_search.
module olirs_checker
  import olirs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic [6:0] res_count;
  assign res_count = m_axis_tdata[28:22];

  // one request in flight: no second request right after acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while previous one still in work");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> res_count <= 7'(CAPACITY))
    else $error("entry count beyond capacity");

  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_FULL |-> res_count == 7'(CAPACITY))
    else $error("list-full status with room left");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_BAD_POS || m_axis_tuser == ST_FULL ||
                      m_axis_tuser == ST_NOT_FOUND)
    |-> m_axis_tdata[21:0] == 22'd0)
    else $error("failed request reports nonzero index or record");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind ordered_list_insert_remove_search olirs_checker u_olirs_checker (.*);
